// File: hw/rtl/anb_pkg.sv
// anb_pkg: shared types, codes and the slice class table of the Annex B scanner
// depends on nothing; used by every module
package anb_pkg;

   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
   localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
   localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
   localparam logic [4:0] NAL_TYPE_AUX = 5'd19;

   localparam logic [2:0] CLASS_SPS = 3'd0;
   localparam logic [2:0] CLASS_PPS = 3'd1;
   localparam logic [2:0] CLASS_I = 3'd2;
   localparam logic [2:0] CLASS_P = 3'd3;
   localparam logic [2:0] CLASS_B = 3'd4;
   localparam logic [2:0] CLASS_SI = 3'd5;
   localparam logic [2:0] CLASS_SP = 3'd6;
   localparam logic [2:0] CLASS_OTHER = 3'd7;

   localparam logic [5:0] MAX_ZERO_BITS = 6'd32;
   localparam logic [0:0] REG_REPORT_MASK = 1'b0;

   // one stream byte as tagged by the front end
   typedef struct packed {
      logic        start;      // byte closes a start code
      logic        long_code;  // three or more zeros came before
      logic [31:0] nal_pos;    // offset of first start-code byte
      logic [7:0]  data;
   } entry_type;

   typedef struct packed {
      logic [4:0]  nal_type;
      logic [2:0]  nal_class;
      logic [2:0]  start_code_len;
      logic [31:0] nal_offset;
      logic [31:0] first_mb;
      logic [7:0]  slice_kind;
      logic        header_error;
   } result_type;

   // slice type code to class, other above nine
   function automatic logic [2:0] class_of_slice(input logic [31:0] st);
      logic [2:0] c;
      c = CLASS_OTHER;
      if (st <= 32'd9) begin
         case (st[3:0])
            4'd0, 4'd5: c = CLASS_P;
            4'd1, 4'd6: c = CLASS_B;
            4'd2, 4'd7: c = CLASS_I;
            4'd3, 4'd8: c = CLASS_SP;
            4'd4, 4'd9: c = CLASS_SI;
            default: c = CLASS_OTHER;
         endcase
      end
      return c;
   endfunction

   function automatic logic is_slice_nal(input logic [4:0] t);
      return (t == NAL_TYPE_SLICE) || (t == NAL_TYPE_IDR) || (t == NAL_TYPE_AUX);
   endfunction

endpackage

// File: hw/rtl/anb_if.sv
// anb_req_if / anb_rsp_if: valid-ready channels of the scanner
// depends on nothing
interface anb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface anb_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  nal_type;
   logic [2:0]  nal_class;
   logic [2:0]  start_code_len;
   logic [31:0] nal_offset;
   logic [31:0] first_mb;
   logic [7:0]  slice_kind;
   logic        header_error;
   modport source (output valid, output nal_type, output nal_class, output start_code_len,
                   output nal_offset, output first_mb, output slice_kind,
                   output header_error, input ready);
   modport sink (input valid, input nal_type, input nal_class, input start_code_len,
                 input nal_offset, input first_mb, input slice_kind,
                 input header_error, output ready);
endinterface

// File: hw/rtl/anb_front.sv
// anb_front: start code tracking and byte offset counting on accepted bytes
// depends on anb_pkg
module anb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [7:0]        data,
   output anb_pkg::entry_type entry
);
   import anb_pkg::*;

   logic [1:0]  zero_run_ff, zero_run_in;
   logic [31:0] pos_ff, pos_in;
   logic        is_start;

   // a 0x01 after two or more zeros closes a start code
   assign is_start = (data == 8'h01) && (zero_run_ff >= 2'd2);

   always_comb begin
      pos_in = pos_ff + 32'd1;
      zero_run_in = zero_run_ff;
      if (is_start) begin
         zero_run_in = 2'd0;
      end else if (data == 8'h00) begin
         if (zero_run_ff != 2'd3) zero_run_in = zero_run_ff + 2'd1;
      end else begin
         zero_run_in = 2'd0;
      end
   end

   always_comb begin
      entry.start = is_start;
      entry.long_code = (zero_run_ff == 2'd3);
      entry.nal_pos = pos_ff - ((zero_run_ff == 2'd3) ? 32'd3 : 32'd2);
      entry.data = data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= 2'd0;
         pos_ff <= 32'd0;
      end else if (push) begin
         zero_run_ff <= zero_run_in;
         pos_ff <= pos_in;
      end
   end
endmodule

// File: hw/rtl/anb_fifo.sv
// anb_fifo: two-entry queue between front end and parser
// depends on anb_pkg
module anb_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  anb_pkg::entry_type push_entry,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output anb_pkg::entry_type head
);
   import anb_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head = slot_ff[rd_ff];

   // payload slots
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: hw/rtl/anb_back.sv
// anb_back: NAL header parse, ue(v) decode eight bits a byte, result register
// depends on anb_pkg
module anb_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  anb_pkg::entry_type  q_entry,
   output logic               q_pop,
   input  logic [7:0]         mask,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output anb_pkg::result_type rsp_data
);
   import anb_pkg::*;

   typedef enum logic [2:0] {
      PH_SEARCH, PH_HEADER, PH_FIRST_PRE, PH_FIRST_SUF, PH_TYPE_PRE, PH_TYPE_SUF
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [5:0] zb_ff, zb_in;
   logic [5:0] sb_ff, sb_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] fmb_ff, fmb_in;
   logic [4:0] type_ff, type_in;
   logic       long_ff, long_in;
   logic [31:0] start_ff, start_in;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   logic       ev;
   logic [2:0] e_cls;
   logic [31:0] e_first;
   logic [7:0] e_kind;
   logic       e_err;
   logic       fire;
   result_type res;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // next state for one queued byte
   always_comb begin
      logic       stop, done, bitv;
      logic [31:0] val;
      phase_in = phase_ff;
      zb_in = zb_ff;
      sb_in = sb_ff;
      acc_in = acc_ff;
      fmb_in = fmb_ff;
      type_in = type_ff;
      long_in = long_ff;
      start_in = start_ff;
      ev = 1'b0;
      e_cls = CLASS_OTHER;
      e_first = 32'd0;
      e_kind = 8'd0;
      e_err = 1'b0;
      stop = 1'b0;
      done = 1'b0;
      bitv = 1'b0;
      val = 32'd0;
      if (q_entry.start) begin
         // start code: any slice header still open is cut
         if (phase_ff != PH_SEARCH && phase_ff != PH_HEADER) begin
            ev = 1'b1;
            e_err = 1'b1;
            e_first = (phase_ff == PH_TYPE_PRE || phase_ff == PH_TYPE_SUF) ? fmb_ff : 32'd0;
         end
         long_in = q_entry.long_code;
         start_in = q_entry.nal_pos;
         phase_in = PH_HEADER;
      end else if (phase_ff == PH_HEADER) begin
         type_in = q_entry.data[4:0];
         fmb_in = 32'd0;
         zb_in = 6'd0;
         sb_in = 6'd0;
         acc_in = 32'd0;
         if (is_slice_nal(q_entry.data[4:0])) begin
            phase_in = PH_FIRST_PRE;
         end else begin
            phase_in = PH_SEARCH;
            ev = 1'b1;
            if (q_entry.data[4:0] == NAL_TYPE_SPS) e_cls = CLASS_SPS;
            else if (q_entry.data[4:0] == NAL_TYPE_PPS) e_cls = CLASS_PPS;
         end
      end else if (phase_ff != PH_SEARCH) begin
         // ue(v) decoding, msb first
         for (int i = 7; i >= 0; i--) begin
            done = 1'b0;
            val = 32'd0;
            if (!stop) begin
               bitv = q_entry.data[i];
               if (phase_in == PH_FIRST_PRE || phase_in == PH_TYPE_PRE) begin
                  if (!bitv) begin
                     zb_in = zb_in + 6'd1;
                     if (zb_in >= MAX_ZERO_BITS) begin
                        ev = 1'b1;
                        e_err = 1'b1;
                        e_first = (phase_in == PH_TYPE_PRE) ? fmb_in : 32'd0;
                        phase_in = PH_SEARCH;
                        stop = 1'b1;
                     end
                  end else if (zb_in == 6'd0) begin
                     done = 1'b1;
                  end else begin
                     sb_in = zb_in;
                     acc_in = 32'd0;
                     phase_in = (phase_in == PH_FIRST_PRE) ? PH_FIRST_SUF : PH_TYPE_SUF;
                  end
               end else begin
                  acc_in = {acc_in[30:0], bitv};
                  sb_in = sb_in - 6'd1;
                  if (sb_in == 6'd0) begin
                     done = 1'b1;
                     val = acc_in + 32'((33'd1 << zb_in[4:0]) - 33'd1);
                  end
               end
               if (done) begin
                  if (phase_in == PH_FIRST_PRE || phase_in == PH_FIRST_SUF) begin
                     fmb_in = val;
                     zb_in = 6'd0;
                     sb_in = 6'd0;
                     acc_in = 32'd0;
                     phase_in = PH_TYPE_PRE;
                  end else begin
                     phase_in = PH_SEARCH;
                     ev = 1'b1;
                     e_cls = class_of_slice(val);
                     e_first = fmb_in;
                     e_kind = (val > 32'd255) ? 8'd255 : val[7:0];
                     stop = 1'b1;
                  end
               end
            end
         end
      end
   end

   // result record and mask filter
   always_comb begin
      res.nal_type = (!q_entry.start && phase_ff == PH_HEADER) ? q_entry.data[4:0] : type_ff;
      res.nal_class = e_cls;
      res.start_code_len = long_ff ? 3'd4 : 3'd3;
      res.nal_offset = start_ff;
      res.first_mb = e_first;
      res.slice_kind = e_kind;
      res.header_error = e_err;
      fire = ev && (e_err || mask[e_cls]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         zb_ff <= 6'd0;
         sb_ff <= 6'd0;
         acc_ff <= 32'd0;
         fmb_ff <= 32'd0;
         type_ff <= 5'd0;
         long_ff <= 1'b0;
         start_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            zb_ff <= zb_in;
            sb_ff <= sb_in;
            acc_ff <= acc_in;
            fmb_ff <= fmb_in;
            type_ff <= type_in;
            long_ff <= long_in;
            start_ff <= start_in;
            rsp_valid_ff <= fire;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_pop && fire) rsp_data_ff <= res;
      end
   end
endmodule

// File: hw/rtl/annexb_nal_header_scanner.sv
// annexb_nal_header_scanner: top level, csr port, front end, queue, parser
// depends on anb_pkg, anb_if, anb_front, anb_fifo, anb_back
//
//   channel | direction | transfer carries
//   req_ch  | in        | stream_byte
//   rsp_ch  | out       | nal_type, nal_class, start_code_len, nal_offset,
//           |           | first_mb, slice_kind, header_error
//   csr     | apb       | report_class_mask at address 0
//
// one byte a cycle unless a result stalls; an accepted byte is tagged by the front end
// into the queue, then parsed from the queue head into the result register
// synchronous active-high reset clears the control state; the mask resets to all ones
// a stalled result holds the parser; the two-entry queue then fills and drops req ready
module annexb_nal_header_scanner (
   input  logic        clock,
   input  logic        reset,
   anb_req_if.sink     req_ch,
   anb_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import anb_pkg::*;

   logic [7:0] mask_ff;
   logic       push, full, q_valid, q_pop, csr_wr;
   entry_type  f_entry, q_head;
   result_type r_data;
   logic       r_valid;

   // config register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_REPORT_MASK);
   assign prdata = (paddr[2] == REG_REPORT_MASK) ? {24'd0, mask_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) mask_ff <= 8'hFF;
      else if (csr_wr) mask_ff <= pwdata[7:0];
   end

   assign req_ch.ready = !full;
   assign push = req_ch.valid && !full;

   anb_front u_front (
      .clock(clock), .reset(reset), .push(push), .data(req_ch.stream_byte), .entry(f_entry)
   );

   anb_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_entry(f_entry), .full(full),
      .pop(q_pop), .not_empty(q_valid), .head(q_head)
   );

   anb_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_entry(q_head), .q_pop(q_pop),
      .mask(mask_ff), .rsp_ready(rsp_ch.ready), .rsp_valid(r_valid), .rsp_data(r_data)
   );

   assign rsp_ch.valid = r_valid;
   assign rsp_ch.nal_type = r_data.nal_type;
   assign rsp_ch.nal_class = r_data.nal_class;
   assign rsp_ch.start_code_len = r_data.start_code_len;
   assign rsp_ch.nal_offset = r_data.nal_offset;
   assign rsp_ch.first_mb = r_data.first_mb;
   assign rsp_ch.slice_kind = r_data.slice_kind;
   assign rsp_ch.header_error = r_data.header_error;

   // checks
   a_mask_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> mask_ff == $past(pwdata[7:0]))
      else $error("mask not updated by csr write");
   a_err_class: assert property (@(posedge clock) disable iff (reset)
      r_valid && r_data.header_error |-> r_data.nal_class == CLASS_OTHER)
      else $error("error result with slice class");
   a_code_len: assert property (@(posedge clock) disable iff (reset)
      r_valid |-> (r_data.start_code_len == 3'd3 || r_data.start_code_len == 3'd4))
      else $error("bad start code length");
endmodule

// File: bench/anb_scan_checker.sv
// anb_scan_checker: watches the byte and result channels of the scanner, predicts each NAL report
// depends on anb_pkg and the channel interfaces in anb_if
`timescale 1ns / 1ps
module anb_scan_checker (
   input  logic        clock,
   input  logic        reset,
   anb_req_if          req_ch,
   anb_rsp_if          rsp_ch,
   input  logic [7:0]  class_mask,
   output int          fail_count,
   output int          pending_count,
   output int          report_count
);
   import anb_pkg::*;

   typedef enum logic [2:0] {
      PH_SEARCH, PH_HEADER, PH_FIRST_PRE, PH_FIRST_SUF, PH_TYPE_PRE, PH_TYPE_SUF
   } phase_t;

   result_type  expected_reports[$];
   logic [1:0]  zeros_seen;
   phase_t      phase;
   logic [31:0] byte_pos;
   logic [31:0] nal_pos;
   logic        long_code;
   logic [4:0]  cur_type;
   logic [5:0]  lead_zeros;
   logic [5:0]  bits_left;
   logic [31:0] suffix_acc;
   logic [31:0] cur_first_mb;

   // queue a report unless its class is masked off; errors always go out
   function automatic void post_report(logic [2:0] cls, logic [31:0] first,
                                       logic [7:0] kind, logic err);
      result_type r;
      if (!err && !class_mask[cls]) return;
      r.nal_type = cur_type;
      r.nal_class = cls;
      r.start_code_len = long_code ? 3'd4 : 3'd3;
      r.nal_offset = nal_pos;
      r.first_mb = first;
      r.slice_kind = kind;
      r.header_error = err;
      expected_reports.push_back(r);
   endfunction

   // run the two ue(v) decoders over one slice header byte, msb first
   function automatic void decode_header_byte(logic [7:0] b);
      logic        bit_v;
      logic        done;
      logic [32:0] val;
      for (int i = 7; i >= 0; i--) begin
         bit_v = b[i];
         done = 1'b0;
         val = '0;
         if (phase == PH_FIRST_PRE || phase == PH_TYPE_PRE) begin
            if (!bit_v) begin
               lead_zeros++;
               if (lead_zeros >= MAX_ZERO_BITS) begin
                  post_report(CLASS_OTHER, (phase == PH_TYPE_PRE) ? cur_first_mb : 32'd0,
                              8'd0, 1'b1);
                  phase = PH_SEARCH;
                  return;
               end
            end else if (lead_zeros == 0) begin
               done = 1'b1;
            end else begin
               bits_left = lead_zeros;
               suffix_acc = '0;
               phase = phase_t'(phase + 1);
            end
         end else if (phase == PH_FIRST_SUF || phase == PH_TYPE_SUF) begin
            suffix_acc = {suffix_acc[30:0], bit_v};
            bits_left--;
            if (bits_left == 0) begin
               done = 1'b1;
               val = (33'd1 << lead_zeros) - 33'd1 + {1'b0, suffix_acc};
            end
         end else begin
            return;
         end
         if (done) begin
            if (phase == PH_FIRST_PRE || phase == PH_FIRST_SUF) begin
               cur_first_mb = val[31:0];
               lead_zeros = '0;
               bits_left = '0;
               suffix_acc = '0;
               phase = PH_TYPE_PRE;
            end else begin
               phase = PH_SEARCH;
               post_report(class_of_slice(val[31:0]), cur_first_mb,
                           (val[31:0] > 32'd255) ? 8'd255 : val[7:0], 1'b0);
               return;
            end
         end
      end
   endfunction

   // advance the scanner state by one stream byte
   function automatic void scan_byte(logic [7:0] b);
      logic [31:0] pos;
      pos = byte_pos;
      byte_pos = pos + 1;
      if (b == 8'h01 && zeros_seen >= 2) begin
         if (phase >= PH_FIRST_PRE && phase <= PH_TYPE_SUF)
            post_report(CLASS_OTHER, (phase >= PH_TYPE_PRE) ? cur_first_mb : 32'd0,
                        8'd0, 1'b1);
         long_code = (zeros_seen == 2'd3);
         nal_pos = pos - (long_code ? 32'd3 : 32'd2);
         zeros_seen = '0;
         phase = PH_HEADER;
         return;
      end
      if (b == 8'h00) begin
         if (zeros_seen < 3) zeros_seen++;
      end else begin
         zeros_seen = '0;
      end
      if (phase == PH_HEADER) begin
         cur_type = b[4:0];
         cur_first_mb = '0;
         lead_zeros = '0;
         bits_left = '0;
         suffix_acc = '0;
         if (is_slice_nal(cur_type)) begin
            phase = PH_FIRST_PRE;
            return;
         end
         phase = PH_SEARCH;
         if (cur_type == NAL_TYPE_SPS) post_report(CLASS_SPS, 0, 0, 0);
         else if (cur_type == NAL_TYPE_PPS) post_report(CLASS_PPS, 0, 0, 0);
         else post_report(CLASS_OTHER, 0, 0, 0);
         return;
      end
      if (phase >= PH_FIRST_PRE && phase <= PH_TYPE_SUF) decode_header_byte(b);
      else phase = PH_SEARCH;
   endfunction

   assign pending_count = expected_reports.size();

   // compare every result transfer against the oldest expectation
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         zeros_seen = '0;
         phase = PH_SEARCH;
         byte_pos = '0;
         nal_pos = '0;
         long_code = 1'b0;
         cur_type = '0;
         lead_zeros = '0;
         bits_left = '0;
         suffix_acc = '0;
         cur_first_mb = '0;
         fail_count <= 0;
         report_count <= 0;
         expected_reports.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.nal_type, rsp_ch.nal_class, rsp_ch.start_code_len,
                    rsp_ch.nal_offset, rsp_ch.first_mb, rsp_ch.slice_kind,
                    rsp_ch.header_error};
            report_count <= report_count + 1;
            if (expected_reports.size() == 0) begin
               if (fail_count < 10) $display("unexpected report %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) $display("report mismatch: exp %p got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) scan_byte(req_ch.stream_byte);
      end
   end
endmodule

// File: bench/tb_top.sv
// tb_top: byte stream stimulus, csr writes and verdict for annexb_nal_header_scanner
// depends on anb_pkg, anb_if, anb_scan_checker and the scanner rtl
`timescale 1ns / 1ps
module tb_top;
   import anb_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   logic [7:0]  class_mask;
   int          fail_count, pending_count, report_count;
   int          src_idle_pct, snk_idle_pct;
   int          idle_cycles;
   int          bytes_sent;

   anb_req_if req_ch();
   anb_rsp_if rsp_ch();

   annexb_nal_header_scanner u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   anb_scan_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .class_mask(class_mask), .fail_count(fail_count),
      .pending_count(pending_count), .report_count(report_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAIL annexb_nal_header_scanner");
         $finish;
      end
   end

   // one byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.stream_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // bit string as bytes, padded with ones
   task automatic send_bits(input logic [127:0] bits, input int nbits);
      logic [7:0] b;
      for (int i = 0; i < nbits; i += 8) begin
         for (int k = 0; k < 8; k++) b[7-k] = (i + k < nbits) ? bits[nbits-1-i-k] : 1'b1;
         send_byte(b);
      end
   endtask

   // ue(v) code appended to a bit string
   task automatic put_ue(inout logic [127:0] bits, inout int n, input logic [31:0] v);
      logic [32:0] code;
      int len;
      code = {1'b0, v} + 33'd1;
      len = 0;
      for (int i = 0; i < 33; i++) if (code[i]) len = i + 1;
      bits = (bits << (2 * len - 1)) | code;
      n += 2 * len - 1;
   endtask

   task automatic start_code(input bit long4);
      if (long4) send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
   endtask

   // whole slice nal with given codes
   task automatic slice_nal(input logic [4:0] t, input logic [31:0] mb, input logic [31:0] st);
      logic [127:0] bits;
      int n;
      bits = '0;
      n = 0;
      start_code(1'($urandom_range(1)));
      send_byte({3'($urandom_range(7)), t});
      put_ue(bits, n, mb);
      put_ue(bits, n, st);
      send_bits(bits, n);
   endtask

   task automatic csr_write(input logic [7:0] v);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_REPORT_MASK, 2'b00}; pwdata <= {24'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      class_mask = v;
   endtask

   // hold off until every expected report is out, then let the pipe settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_ue_value();
      case ($urandom_range(5))
         0: return $urandom_range(3);
         1: return $urandom_range(9);
         2: return $urandom_range(300);
         3: return $urandom_range(70000);
         4: return $urandom;
         default: return 32'hFFFF_FFFE;
      endcase
   endfunction

   // random nal: mostly slices and random header bytes, some noise and cut headers
   task automatic random_nal();
      logic [4:0] t;
      int kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2, 3: begin
            case ($urandom_range(2))
               0: t = NAL_TYPE_SLICE;
               1: t = NAL_TYPE_IDR;
               default: t = NAL_TYPE_AUX;
            endcase
            slice_nal(t, rand_ue_value(), ($urandom_range(3) == 0) ? rand_ue_value()
                                                                   : $urandom_range(9));
         end
         4: begin
            start_code(1'($urandom_range(1)));
            send_byte({3'($urandom_range(7)), NAL_TYPE_SLICE});
            send_byte(8'h00);
         end
         5: begin
            start_code(1'($urandom_range(1)));
            send_byte({3'($urandom_range(7)), NAL_TYPE_IDR});
            repeat (5) send_byte(8'h00);
         end
         default: begin
            start_code(1'($urandom_range(1)));
            send_byte(8'($urandom_range(255)));
         end
      endcase
      repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      logic [7:0] masks[4];
      req_ch.valid = 1'b0;
      req_ch.stream_byte = '0;
      rsp_ch.ready = 1'b0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      class_mask = 8'hFF;
      src_idle_pct = 0;
      snk_idle_pct = 0;
      bytes_sent = 0;
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: all classes but B and SP, start code lengths, field extremes, errors
      slice_nal(NAL_TYPE_SLICE, 0, 0);
      slice_nal(NAL_TYPE_IDR, 5, 2);
      slice_nal(NAL_TYPE_AUX, 32'hFFFF_FFFE, 9);
      slice_nal(NAL_TYPE_SLICE, 1, 4);
      slice_nal(NAL_TYPE_SLICE, 7, 33);
      start_code(1); send_byte(8'h67);
      start_code(0); send_byte(8'hE8);
      start_code(0); send_byte(8'hFF);
      // overlong code in first_mb, then in slice type
      start_code(0); send_byte(8'h01); repeat (4) send_byte(8'h00); send_byte(8'h80);
      start_code(1); send_byte(8'h05); send_byte(8'h80); repeat (4) send_byte(8'h00);
      send_byte(8'hFF);
      // header cut by the next start code
      start_code(0); send_byte(8'h01); send_byte(8'h00); start_code(0); send_byte(8'h07);
      drain();

      masks = '{8'h00, 8'hA5, 8'h5A, 8'hFF};
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(masks[ph]);
         src_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 47 : 0;
         snk_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 32 : 0;
         repeat (18) random_nal();
         drain();
      end

      $display("summary: %0d stream bytes, %0d reports, four class masks incl. none and all",
               bytes_sent, report_count);
      if (fail_count == 0) begin
         $display("PASS annexb_nal_header_scanner");
      end else begin
         $display("FAIL annexb_nal_header_scanner");
      end
      $finish;
   end
endmodule
